// ----- design/gcsd_pkg.sv -----
// Package for the cycle slip detector: widths, register indexes, state codes.
// Used by every module of the design.
`timescale 1ns / 1ps

package gcsd_pkg;

  localparam int PrnSlots = 64;
  localparam int PrnBits = $clog2(PrnSlots);
  localparam int IdxBits = PrnBits + 1;
  localparam int Depth = 2 * PrnSlots;

  localparam int InW = 40;
  localparam int GfW = 41;
  localparam int MwW = 48;
  localparam int CntW = 16;
  localparam int NumW = 64;

  typedef enum logic [2:0] {
    CFG_GPS_WL = 3'd0,
    CFG_GPS_NL = 3'd1,
    CFG_BDS_WL = 3'd2,
    CFG_BDS_NL = 3'd3,
    CFG_GF_LIM = 3'd4,
    CFG_MW_LIM = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_FIRST = 2'd0,
    ST_CLEAN = 2'd1,
    ST_SLIP = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MUL_WL,
    S_MUL_NL,
    S_ROUND,
    S_READ,
    S_CMP,
    S_DIV,
    S_UPD,
    S_OUT
  } fsm_t;

endpackage

// ----- design/gcsd_mul.sv -----
// Bit-serial multiplier: a 64-bit signed operand times an unsigned 20-bit factor.
// One factor bit per cycle, shift and add. Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [gcsd_pkg::NumW-1:0] mcand,
  input  logic [19:0] factor,
  output logic busy,
  output logic signed [gcsd_pkg::NumW-1:0] product
);

  logic [19:0] mplier;
  logic signed [gcsd_pkg::NumW-1:0] addend;
  logic [4:0] count;

  // Each cycle adds the shifted multiplicand when the current factor bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 5'd20;
      mplier <= factor;
      addend <= mcand;
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + addend;
      end
      mplier <= mplier >> 1;
      addend <= addend <<< 1;
      count <= count - 5'd1;
      if (count == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- design/gcsd_div.sv -----
// Restoring divider, one quotient bit per cycle: 49-bit dividend by 17-bit divisor.
// Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [gcsd_pkg::MwW:0] dividend,
  input  logic [gcsd_pkg::CntW:0] divisor,
  output logic busy,
  output logic [gcsd_pkg::MwW:0] quotient
);

  localparam int QW = gcsd_pkg::MwW + 1;
  localparam int RW = gcsd_pkg::CntW + 2;

  logic [RW-1:0] rem;
  logic [RW-1:0] trial;
  logic [gcsd_pkg::CntW:0] dsr;
  logic [5:0] count;

  assign trial = {rem[RW-2:0], quotient[QW-1]} - {1'b0, dsr};

  // Shift one dividend bit into the remainder and try a subtraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'(QW);
      quotient <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[RW-1]) begin
        rem <= trial;
        quotient <= {quotient[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[RW-2:0], quotient[QW-1]};
        quotient <= {quotient[QW-2:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- design/gcsd_table.sv -----
// Per-satellite entry table: GF, MW average and count in one memory.
// Registered read, one write port. Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_table (
  input  logic clk,
  input  logic [gcsd_pkg::IdxBits-1:0] rd_addr,
  output logic [gcsd_pkg::GfW+gcsd_pkg::MwW+gcsd_pkg::CntW-1:0] rd_data,
  input  logic wr_en,
  input  logic [gcsd_pkg::IdxBits-1:0] wr_addr,
  input  logic [gcsd_pkg::GfW+gcsd_pkg::MwW+gcsd_pkg::CntW-1:0] wr_data
);

  logic [gcsd_pkg::GfW+gcsd_pkg::MwW+gcsd_pkg::CntW-1:0] mem [gcsd_pkg::Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/gnss_cycle_slip_detector.sv -----
// Cycle slip detector top level: sequencer, config registers and result register.
// One item at a time. A clean track passes two serial multiplies, a serial divide
// and control steps; a first sighting or slip skips the divide; an incomplete
// observation goes straight to the result. Input is taken again in the cycle after
// the result transfer, so output stalls add directly. After reset a clearing pass resets
// the used marks with no item taken; config registers return to their default values.
`timescale 1ns / 1ps

module gnss_cycle_slip_detector (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic sat_system,
  input  logic [5:0] sat_prn,
  input  logic signed [39:0] code_first,
  input  logic signed [39:0] code_second,
  input  logic signed [39:0] phase_first,
  input  logic signed [39:0] phase_second,
  input  logic last_in_epoch,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] slip_status,
  output logic signed [40:0] gf_value,
  output logic signed [47:0] mw_value,
  output logic signed [47:0] mw_smoothed,
  output logic [15:0] track_count,
  output logic epoch_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int NumW = gcsd_pkg::NumW;
  localparam int MwW = gcsd_pkg::MwW;
  localparam int GfW = gcsd_pkg::GfW;
  localparam int CntW = gcsd_pkg::CntW;
  localparam int IB = gcsd_pkg::IdxBits;
  localparam int EW = GfW + MwW + CntW;
  localparam logic signed [NumW-1:0] MwMax = NumW'(64'sd140737488355327);
  localparam logic signed [NumW-1:0] MwMin = -MwMax - NumW'(64'sd1);

  // Configuration registers.
  logic [19:0] gps_wl, bds_wl, gf_lim, mw_lim;
  logic [16:0] gps_nl, bds_nl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gps_wl <= 20'd296839;
      gps_nl <= 17'd36834;
      bds_wl <= 20'd349678;
      bds_nl <= 17'd36156;
      gf_lim <= 20'd51;
      mw_lim <= 20'd3072;
    end else if (cfg_valid) begin
      case (gcsd_pkg::cfg_idx_t'(cfg_index))
        gcsd_pkg::CFG_GPS_WL: gps_wl <= cfg_data;
        gcsd_pkg::CFG_GPS_NL: gps_nl <= cfg_data[16:0];
        gcsd_pkg::CFG_BDS_WL: bds_wl <= cfg_data;
        gcsd_pkg::CFG_BDS_NL: bds_nl <= cfg_data[16:0];
        gcsd_pkg::CFG_GF_LIM: gf_lim <= cfg_data;
        gcsd_pkg::CFG_MW_LIM: mw_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  // Registers of the item in work.
  gcsd_pkg::fsm_t state, state_next;
  logic [IB-1:0] idx;
  logic sys;
  logic eoe;
  logic signed [GfW-1:0] dl, dp;
  logic signed [NumW-1:0] acc;
  logic signed [MwW-1:0] mw, avg;
  logic [CntW-1:0] cnt;
  logic [1:0] status;
  logic [gcsd_pkg::Depth-1:0] used;
  logic [IB-1:0] clr_idx;
  logic [IB:0] clr_cnt;
  logic signed [MwW:0] dmw;
  logic dmw_neg;
  logic [CntW-1:0] old_cnt;

  // Table, multiplier and divider.
  logic [EW-1:0] rd_data, wr_data;
  logic wr_en;
  logic signed [GfW-1:0] ent_gf;
  logic signed [MwW-1:0] ent_avg;
  logic [CntW-1:0] ent_cnt;

  assign {ent_gf, ent_avg, ent_cnt} = rd_data;
  assign wr_data = {dl, avg, cnt};

  // MW jump against the stored average; the entry stays put until the update step.
  assign dmw = {mw[MwW-1], mw} - {ent_avg[MwW-1], ent_avg};

  gcsd_table u_table (
    .clk(clk), .rd_addr(idx), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(idx), .wr_data(wr_data)
  );

  logic mul_start, mul_busy, div_start, div_busy;
  logic signed [NumW-1:0] mul_cand;
  logic [19:0] mul_fac;
  logic signed [NumW-1:0] prod;
  logic [MwW:0] quo;
  logic [MwW:0] div_num;

  gcsd_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_cand),
    .factor(mul_fac), .busy(mul_busy), .product(prod)
  );

  gcsd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor({1'b0, old_cnt} + 17'd1), .busy(div_busy), .quotient(quo)
  );

  // Magnitude plus half the divisor gives round-to-nearest.
  assign div_num = (dmw_neg ? (MwW+1)'(-dmw) : (MwW+1)'(dmw))
                   + (MwW+1)'((({1'b0, old_cnt} + 17'd1) >> 1));

  logic signed [NumW-1:0] rnd;
  logic signed [NumW-1:0] sum_avg;
  logic signed [GfW:0] dgf;
  logic gf_bad, mw_bad;

  assign rnd = (acc + NumW'(64'sd32768)) >>> 16;
  assign dgf = {dl[GfW-1], dl} - {ent_gf[GfW-1], ent_gf};
  assign gf_bad = (dgf < 0 ? -dgf : dgf) > $signed({22'd0, gf_lim});
  assign mw_bad = (dmw < 0 ? -dmw : dmw) > $signed({29'd0, mw_lim});
  assign sum_avg = NumW'(ent_avg) + (dmw_neg ? -NumW'(quo) : NumW'(quo));

  assign mul_cand = (state == gcsd_pkg::S_MUL_WL) ? NumW'(dl) : -NumW'(dp);
  assign mul_fac = (state == gcsd_pkg::S_MUL_WL) ? (sys ? bds_wl : gps_wl)
                 : {3'd0, sys ? bds_nl : gps_nl};

  logic started;

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    wr_en = 1'b0;
    case (state)
      gcsd_pkg::S_CLEAR: if (clr_cnt == (IB+1)'(gcsd_pkg::Depth - 1)) begin
        state_next = gcsd_pkg::S_IDLE;
      end
      gcsd_pkg::S_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && !out_valid) begin
          if (code_first == 0 || code_second == 0 || phase_first == 0
              || phase_second == 0) begin
            state_next = gcsd_pkg::S_OUT;
          end else begin
            state_next = gcsd_pkg::S_MUL_WL;
          end
        end
      end
      gcsd_pkg::S_MUL_WL, gcsd_pkg::S_MUL_NL: begin
        mul_start = !started;
        if (started && !mul_busy) begin
          state_next = (state == gcsd_pkg::S_MUL_WL) ? gcsd_pkg::S_MUL_NL
                     : gcsd_pkg::S_ROUND;
        end
      end
      gcsd_pkg::S_ROUND: state_next = gcsd_pkg::S_READ;
      gcsd_pkg::S_READ: state_next = gcsd_pkg::S_CMP;
      gcsd_pkg::S_CMP: begin
        if (used[idx] && !(gf_bad || mw_bad)) begin
          state_next = gcsd_pkg::S_DIV;
        end else begin
          state_next = gcsd_pkg::S_UPD;
        end
      end
      gcsd_pkg::S_DIV: begin
        div_start = !started;
        if (started && !div_busy) begin
          state_next = gcsd_pkg::S_UPD;
        end
      end
      gcsd_pkg::S_UPD: begin
        wr_en = 1'b1;
        state_next = gcsd_pkg::S_OUT;
      end
      gcsd_pkg::S_OUT: state_next = gcsd_pkg::S_IDLE;
      default: state_next = gcsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcsd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Data path steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      clr_cnt <= '0;
      clr_idx <= '0;
      started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      started <= (state == state_next) && (mul_start || div_start || started);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        gcsd_pkg::S_CLEAR: begin
          used[clr_idx] <= 1'b0;
          clr_idx <= clr_idx + IB'(1);
          clr_cnt <= clr_cnt + (IB+1)'(1);
        end
        gcsd_pkg::S_IDLE: if (in_valid && !out_valid) begin
          sys <= sat_system;
          idx <= {sat_system, sat_prn[gcsd_pkg::PrnBits-1:0]};
          eoe <= last_in_epoch;
          dl <= GfW'(phase_first) - GfW'(phase_second);
          dp <= GfW'(code_first) - GfW'(code_second);
          acc <= (NumW'(phase_second) - NumW'(code_second)) <<< 16;
          status <= gcsd_pkg::ST_INCOMPLETE;
          mw <= '0;
          avg <= '0;
          cnt <= '0;
        end
        gcsd_pkg::S_MUL_WL, gcsd_pkg::S_MUL_NL: if (started && !mul_busy) begin
          acc <= acc + prod;
        end
        gcsd_pkg::S_ROUND: begin
          mw <= (rnd > MwMax) ? MwW'(MwMax) : (rnd < MwMin) ? MwW'(MwMin) : MwW'(rnd);
        end
        gcsd_pkg::S_READ: ;
        gcsd_pkg::S_CMP: begin
          dmw_neg <= mw < ent_avg;
          old_cnt <= ent_cnt;
          if (!used[idx]) begin
            status <= gcsd_pkg::ST_FIRST;
            avg <= mw;
            cnt <= CntW'(1);
          end else if (gf_bad || mw_bad) begin
            status <= gcsd_pkg::ST_SLIP;
            avg <= mw;
            cnt <= CntW'(1);
          end else begin
            status <= gcsd_pkg::ST_CLEAN;
            cnt <= (ent_cnt == '1) ? ent_cnt : ent_cnt + CntW'(1);
          end
        end
        gcsd_pkg::S_DIV: if (started && !div_busy) begin
          avg <= (sum_avg > MwMax) ? MwW'(MwMax)
               : (sum_avg < MwMin) ? MwW'(MwMin) : MwW'(sum_avg);
        end
        gcsd_pkg::S_UPD: used[idx] <= 1'b1;
        gcsd_pkg::S_OUT: begin
          out_valid <= 1'b1;
          slip_status <= status;
          gf_value <= (status == gcsd_pkg::ST_INCOMPLETE) ? '0 : dl;
          mw_value <= mw;
          mw_smoothed <= avg;
          track_count <= cnt;
          epoch_end <= eoe;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sim/tb_gnss_cycle_slip_detector.sv -----
// Self-checking testbench for the GNSS cycle slip detector.
// Depends on gcsd_pkg and gnss_cycle_slip_detector; a built-in predictor tracks
// the satellite table and the config registers and checks every result transfer.
`timescale 1ns / 1ps

module tb_gnss_cycle_slip_detector;

  typedef struct {
    gcsd_pkg::status_t st;
    logic signed [40:0] gf;
    logic signed [47:0] mw;
    logic signed [47:0] avg;
    logic [15:0] cnt;
    logic eoe;
  } slip_result_t;

  localparam longint MwMax = 64'sd140737488355327;
  localparam longint MwMin = -MwMax - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic sat_system = 1'b0;
  logic [5:0] sat_prn = '0;
  logic signed [39:0] code_first = '0;
  logic signed [39:0] code_second = '0;
  logic signed [39:0] phase_first = '0;
  logic signed [39:0] phase_second = '0;
  logic last_in_epoch = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] slip_status;
  logic signed [40:0] gf_value;
  logic signed [47:0] mw_value;
  logic signed [47:0] mw_smoothed;
  logic [15:0] track_count;
  logic epoch_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  gnss_cycle_slip_detector u_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the config registers and the satellite table.
  longint gps_wl = 296839, gps_nl = 36834, bds_wl = 349678, bds_nl = 36156;
  longint gf_lim = 51, mw_lim = 3072;
  bit     sat_used [gcsd_pkg::Depth];
  longint sat_gf [gcsd_pkg::Depth];
  longint sat_avg [gcsd_pkg::Depth];
  int     sat_cnt [gcsd_pkg::Depth];

  // Per-satellite trajectory used to build continuous random tracks.
  bit     trk_live [gcsd_pkg::Depth];
  longint trk_p1 [gcsd_pkg::Depth], trk_p2 [gcsd_pkg::Depth];
  longint trk_l1 [gcsd_pkg::Depth], trk_l2 [gcsd_pkg::Depth];

  slip_result_t pending_results[$];
  int err_count = 0;
  int obs_sent = 0;
  int results_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint sat48(input longint v);
    if (v > MwMax) return MwMax;
    if (v < MwMin) return MwMin;
    return v;
  endfunction

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Expected result of one observation; also updates the shadow table.
  function automatic slip_result_t predict_slip(input logic sys, input logic [5:0] prn,
                                                input longint p1, input longint p2,
                                                input longint l1, input longint l2,
                                                input logic last);
    slip_result_t r;
    int idx;
    longint wl, nl, num, q, mw, gf, dgf, dmw, dv, stp, avg;
    int cnt;
    idx = (sys ? gcsd_pkg::PrnSlots : 0) + (prn % gcsd_pkg::PrnSlots);
    r.st = gcsd_pkg::ST_INCOMPLETE;
    r.gf = '0;
    r.mw = '0;
    r.avg = '0;
    r.cnt = '0;
    r.eoe = last;
    if (p1 == 0 || p2 == 0 || l1 == 0 || l2 == 0) return r;
    wl = sys ? bds_wl : gps_wl;
    nl = sys ? bds_nl : gps_nl;
    num = (l2 - p2) * 65536 + wl * (l1 - l2) - nl * (p1 - p2);
    // Round half up, then floor via arithmetic shift.
    q = (num + 32768) >>> 16;
    mw = sat48(q);
    gf = l1 - l2;
    if (sat_used[idx]) begin
      dgf = gf - sat_gf[idx];
      dmw = mw - sat_avg[idx];
      if (abs_l(dgf) > gf_lim || abs_l(dmw) > mw_lim) begin
        r.st = gcsd_pkg::ST_SLIP;
        avg = mw;
        cnt = 1;
      end else begin
        dv = longint'(sat_cnt[idx]) + 1;
        stp = (abs_l(dmw) + dv / 2) / dv;
        r.st = gcsd_pkg::ST_CLEAN;
        avg = sat48(sat_avg[idx] + ((dmw < 0) ? -stp : stp));
        cnt = (sat_cnt[idx] >= 65535) ? 65535 : sat_cnt[idx] + 1;
      end
    end else begin
      r.st = gcsd_pkg::ST_FIRST;
      avg = mw;
      cnt = 1;
    end
    sat_used[idx] = 1'b1;
    sat_gf[idx] = gf;
    sat_avg[idx] = avg;
    sat_cnt[idx] = cnt;
    r.gf = gf[40:0];
    r.mw = mw[47:0];
    r.avg = avg[47:0];
    r.cnt = cnt[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Result side: random backpressure, driven at the falling edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    slip_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = pending_results.pop_front();
        status_seen[slip_status]++;
        if (slip_status !== e.st)
          report_mismatch($sformatf("slip_status %0d, expected %0d", slip_status, e.st));
        if (gf_value !== e.gf)
          report_mismatch($sformatf("gf_value %0d, expected %0d", gf_value, e.gf));
        if (mw_value !== e.mw)
          report_mismatch($sformatf("mw_value %0d, expected %0d", mw_value, e.mw));
        if (mw_smoothed !== e.avg)
          report_mismatch($sformatf("mw_smoothed %0d, expected %0d", mw_smoothed, e.avg));
        if (track_count !== e.cnt)
          report_mismatch($sformatf("track_count %0d, expected %0d", track_count, e.cnt));
        if (epoch_end !== e.eoe)
          report_mismatch($sformatf("epoch_end %0b, expected %0b", epoch_end, e.eoe));
      end
    end
  end

  // Send one observation; entered and left at a falling edge.
  task automatic send_obs(input logic sys, input logic [5:0] prn,
                          input longint p1, input longint p2,
                          input longint l1, input longint l2, input logic last);
    slip_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sat_system = sys;
    sat_prn = prn;
    code_first = p1[39:0];
    code_second = p2[39:0];
    phase_first = l1[39:0];
    phase_second = l2[39:0];
    last_in_epoch = last;
    do @(posedge clk); while (!in_ready);
    exp_res = predict_slip(sys, prn, longint'(code_first), longint'(code_second),
                           longint'(phase_first), longint'(phase_second), last);
    pending_results.insert(pending_results.size(), exp_res);
    obs_sent++;
    @(negedge clk);
  endtask

  // Hold off input until every expected result has come, then let the block settle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input gcsd_pkg::cfg_idx_t idx, input logic [19:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gcsd_pkg::CFG_GPS_WL: gps_wl = longint'(val);
      gcsd_pkg::CFG_GPS_NL: gps_nl = longint'(val[16:0]);
      gcsd_pkg::CFG_BDS_WL: bds_wl = longint'(val);
      gcsd_pkg::CFG_BDS_NL: bds_nl = longint'(val[16:0]);
      gcsd_pkg::CFG_GF_LIM: gf_lim = longint'(val);
      gcsd_pkg::CFG_MW_LIM: mw_lim = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [19:0] gwl, input logic [19:0] gnl,
                           input logic [19:0] bwl, input logic [19:0] bnl,
                           input logic [19:0] glim, input logic [19:0] mlim);
    write_reg(gcsd_pkg::CFG_GPS_WL, gwl);
    write_reg(gcsd_pkg::CFG_GPS_NL, gnl);
    write_reg(gcsd_pkg::CFG_BDS_WL, bwl);
    write_reg(gcsd_pkg::CFG_BDS_NL, bnl);
    write_reg(gcsd_pkg::CFG_GF_LIM, glim);
    write_reg(gcsd_pkg::CFG_MW_LIM, mlim);
  endtask

  function automatic longint rand40();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return longint'($signed(t[39:0]));
  endfunction

  function automatic longint jitter(input int n);
    return longint'($urandom_range(2 * n)) - n;
  endfunction

  function automatic longint nz(input longint v);
    return (v == 0) ? 1 : v;
  endfunction

  // One random observation: mostly continuous tracks, some jumps, noise and gaps.
  task automatic send_random_obs();
    logic sys;
    logic [5:0] prn;
    int idx, k;
    longint d, p1, p2, l1, l2;
    sys = 1'($urandom_range(1));
    prn = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
    idx = (sys ? gcsd_pkg::PrnSlots : 0) + prn;
    k = $urandom_range(99);
    if (k < 8) begin
      send_obs(sys, prn, rand40(), rand40(), rand40(), rand40(), 1'($urandom_range(1)));
    end else begin
      if (!trk_live[idx] || k < 16) begin
        trk_p1[idx] = nz(rand40() >>> 3);
        trk_p2[idx] = trk_p1[idx] + jitter(4000);
        trk_l1[idx] = trk_p1[idx] + jitter(100000);
        trk_l2[idx] = trk_l1[idx] + jitter(60000);
        trk_live[idx] = 1'b1;
      end else begin
        // Common geometric motion keeps GF and MW steady; small noise on top.
        d = jitter(262144);
        trk_p1[idx] = nz(trk_p1[idx] + d + jitter(300));
        trk_p2[idx] = nz(trk_p2[idx] + d + jitter(300));
        trk_l1[idx] = nz(trk_l1[idx] + d + jitter(12));
        trk_l2[idx] = nz(trk_l2[idx] + d + jitter(12));
        if (k < 21) trk_l1[idx] = nz(trk_l1[idx] + jitter(8000));
        else if (k < 25) trk_p1[idx] = nz(trk_p1[idx] + jitter(400000));
      end
      p1 = trk_p1[idx];
      p2 = trk_p2[idx];
      l1 = trk_l1[idx];
      l2 = trk_l2[idx];
      // A few observations lose one of the four values.
      if (k >= 95) begin
        case ($urandom_range(3))
          0: p1 = 0;
          1: p2 = 0;
          2: l1 = 0;
          default: l2 = 0;
        endcase
      end
      send_obs(sys, prn, p1, p2, l1, l2, 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random_obs();
  endtask

  // Directed cases with the reset register values.
  task automatic test_directed();
    longint b;
    b = 64'sd20000000000;
    send_obs(1'b0, 6'd5, 0, b, b, b, 1'b0);
    send_obs(1'b0, 6'd5, b, 0, b, b, 1'b1);
    send_obs(1'b0, 6'd5, b, b, 0, b, 1'b0);
    send_obs(1'b0, 6'd5, b, b, b, 0, 1'b1);
    send_obs(1'b0, 6'd5, 0, 0, 0, 0, 1'b0);
    send_obs(1'b0, 6'd5, b, b + 200, b + 900, b + 500, 1'b0);
    send_obs(1'b0, 6'd5, b + 1000, b + 1200, b + 1905, b + 1502, 1'b1);
    send_obs(1'b0, 6'd5, b + 2000, b + 2200, b + 2900, b + 2500, 1'b0);
    send_obs(1'b0, 6'd5, b + 3000, b + 3200, b + 3900 + 1000, b + 3500, 1'b0);
    send_obs(1'b0, 6'd5, b + 4000 + 100000, b + 4200, b + 4900 + 1000, b + 4500, 1'b1);
    send_obs(1'b1, 6'd63, 64'sd549755813887, -64'sd549755813888,
             64'sd549755813887, -64'sd549755813888, 1'b1);
    send_obs(1'b1, 6'd63, -64'sd549755813888, 64'sd549755813887,
             -64'sd549755813888, 64'sd549755813887, 1'b0);
    send_obs(1'b1, 6'd0, 1, -1, 1, -1, 1'b0);
    send_obs(1'b1, 6'd0, 1, -1, 1, -1, 1'b1);
    send_obs(1'b0, 6'd63, -1, -1, -1, -1, 1'b0);
    send_obs(1'b1, 6'd63, -1, -1, -1, -1, 1'b1);
    send_obs(1'b0, 6'd63, -2, -2, -2, -2, 1'b0);
    send_obs(1'b1, 6'd32, 64'sd549755813887, 64'sd549755813887,
             64'sd549755813887, 64'sd549755813887, 1'b1);
  endtask

  // Register sweeps: defaults, wide limits, zero limits, zero and full factors.
  task automatic test_config_sweep();
    write_all(20'd296839, 20'd36834, 20'd349678, 20'd36156, 20'd51, 20'd3072);
    run_random(60, 15, 15);
    write_all(20'hFFFFF, 20'd65536, 20'hFFFFF, 20'd65536, 20'hFFFFF, 20'hFFFFF);
    run_random(60, 15, 15);
    write_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    run_random(60, 15, 15);
    write_all(20'd65536, 20'd32768, 20'd131072, 20'd1, 20'd5000, 20'd40000);
    run_random(60, 15, 15);
    write_all(20'd300000, 20'd40000, 20'd350000, 20'd36000, 20'd60, 20'd3500);
    run_random(60, 15, 15);
    write_all(20'd296839, 20'd36834, 20'd349678, 20'd36156, 20'd51, 20'd3072);
  endtask

  task automatic test_flow_phases();
    run_random(125, 0, 0);
    run_random(60, 57, 0);
    wait_drained();
    run_random(65, 57, 0);
    run_random(125, 0, 57);
    run_random(125, 15, 15);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_sweep();
    test_flow_phases();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (pending_results.size() != 0) report_mismatch("expected results left over");
    $display("Sent %0d observations through %0d register settings; %0d results checked.",
             obs_sent, 6, results_seen);
    $display("Status counts: first %0d, clean %0d, slip %0d, incomplete %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0) begin
      $display("PASS gnss_cycle_slip_detector");
    end else begin
      $display("FAIL gnss_cycle_slip_detector");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50ms;
    $display("FAIL gnss_cycle_slip_detector");
    $finish;
  end

endmodule

// ----- files.f -----
design/gcsd_pkg.sv
design/gcsd_mul.sv
design/gcsd_div.sv
design/gcsd_table.sv
design/gnss_cycle_slip_detector.sv
sim/tb_gnss_cycle_slip_detector.sv
